@@ hdl/gcfv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gcfv_pkg;
    localparam int VramCols   = 1024;
    localparam int VramRows   = 512;
    localparam int QueueDepth = 16;

    typedef enum logic [1:0] {
        OP_WR_GP0 = 2'd0,
        OP_WR_GP1 = 2'd1,
        OP_RD_GP0 = 2'd2,
        OP_RD_GP1 = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_READ = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_DROPPED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        XF_NONE     = 2'd0,
        XF_UPLOAD   = 2'd1,
        XF_DOWNLOAD = 2'd2
    } t_xfer;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_XFER_SETUP,
        S_DROP,
        S_RD0,
        S_RD1,
        S_RD2,
        S_UPL,
        S_OUT
    } t_state;

    localparam logic [7:0] CmdRectVar = 8'h60;
    localparam logic [7:0] CmdRect1   = 8'h68;
    localparam logic [7:0] CmdRect8   = 8'h70;
    localparam logic [7:0] CmdRect16  = 8'h78;
    localparam logic [7:0] CmdOffset  = 8'hE5;
    localparam logic [7:0] CmdClass   = 8'hE0;
    localparam logic [7:0] CmdUpload  = 8'hA0;
    localparam logic [7:0] CmdDownld  = 8'hC0;
    localparam logic [7:0] Gp1Reset   = 8'h01;
    localparam logic [7:0] Gp1Dma     = 8'h04;
    localparam logic [31:0] AllOnes   = 32'hFFFF_FFFF;
    localparam logic [23:0] ColorMask = 24'hFF_FFFF;
endpackage
`default_nettype wire

@@ hdl/gcfv_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface gcfv_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] data_word;
    modport source (output valid, output opcode, output data_word, input ready);
    modport sink (input valid, input opcode, input data_word, output ready);
endinterface

interface gcfv_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [1:0]  status_code;
    modport source (output valid, output read_data, output status_code, input ready);
    modport sink (input valid, input read_data, input status_code, output ready);
endinterface
`default_nettype wire

@@ hdl/gpu_command_fifo_vram_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// gp1 writes, refused words and bad reads go straight to the result beat; an upload word
// moves through S_UPL, S_RD2 and S_DROP, a download read through S_RD1, S_RD2 and S_DROP,
// and a queued gp0 word through S_RD0 and S_DECODE, plus S_XFER_SETUP when it starts a transfer
// a fill steps through S_FILL, one pixel per cycle through the single vram write port
// throughput: one item at a time; the next beat is taken the cycle after the result leaves
// reset (synchronous, active low) clears queue count, transfer, offset and dma state
module gpu_command_fifo_vram_engine #(
    parameter int QUEUE_DEPTH = gcfv_pkg::QueueDepth
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    gcfv_in_if.sink    i_in,
    gcfv_out_if.source o_out
);
    localparam int VRAM_COLS = gcfv_pkg::VramCols;
    localparam int VRAM_ROWS = gcfv_pkg::VramRows;
    localparam int CW = $clog2(VRAM_COLS);
    localparam int RW = $clog2(VRAM_ROWS);
    localparam int AW = CW + RW;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int NW = QW + 1;
    localparam logic [NW-1:0] QFULL = NW'(QUEUE_DEPTH);

    localparam logic [7:0] CmdRectVar = gcfv_pkg::CmdRectVar;
    localparam logic [7:0] CmdRect1   = gcfv_pkg::CmdRect1;
    localparam logic [7:0] CmdRect8   = gcfv_pkg::CmdRect8;
    localparam logic [7:0] CmdRect16  = gcfv_pkg::CmdRect16;
    localparam logic [7:0] CmdOffset  = gcfv_pkg::CmdOffset;

    // ring index, folds a head-relative sum back into the queue depth
    function automatic logic [QW-1:0] q_idx(input logic [NW:0] sum);
        logic [NW:0] folded;
        folded = (sum >= (NW+1)'(QUEUE_DEPTH)) ? sum - (NW+1)'(QUEUE_DEPTH) : sum;
        return QW'(folded);
    endfunction

    // memories
    logic [15:0] r_vram [0:(1<<AW)-1];
    logic [31:0] r_queue [0:QUEUE_DEPTH-1];

    gcfv_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_qcnt, n_qcnt;
    logic [NW-1:0] r_qhead, n_qhead;     // ring head; only low QW bits used modulo depth
    logic [1:0]  r_xmode, n_xmode;
    logic [AW-1:0] r_xaddr, n_xaddr;
    logic [CW:0] r_xwidth, n_xwidth;
    logic [CW:0] r_xstride, n_xstride;
    logic [CW:0] r_cols, n_cols;
    logic [RW:0] r_rows, n_rows;
    logic [10:0] r_offx, n_offx, r_offy, n_offy;
    logic [1:0]  r_dma, n_dma;
    logic [31:0] r_data, n_data;
    logic [1:0]  r_code, n_code;
    logic [31:0] r_word, n_word;
    logic [31:0] r_w0, n_w0, r_w1, n_w1, r_w2, n_w2;
    logic [1:0]  r_rdsel, n_rdsel;
    // fill walker
    logic [10:0] r_fw, n_fw, r_fx, n_fx;
    logic [9:0]  r_fh, n_fh, r_fy, n_fy;
    logic [15:0] r_pix, n_pix;
    logic [AW-1:0] r_rowa, n_rowa;

    // queue read and write ports
    logic [QW-1:0] w_qra;
    logic [31:0]   r_qrd;
    logic          w_qwe;
    logic [QW-1:0] w_qwa;
    // vram ports
    logic          w_vwe;
    logic [AW-1:0] w_vwa, w_vra;
    logic [15:0]   w_vwd, r_vrd;

    always_ff @(posedge i_clk) begin
        if (w_qwe) begin
            r_queue[w_qwa] <= r_word;
        end
        r_qrd <= r_queue[w_qra];
    end

    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_vram[w_vwa] <= w_vwd;
        end
        r_vrd <= r_vram[w_vra];
    end

    // helper values
    logic [NW-1:0] w_need;
    logic [7:0]    w_cmd;
    logic [AW-1:0] w_adv2, w_advs;
    logic [16:0]   w_rx, w_ry;
    logic [16:0]   w_mw;
    logic [CW:0]   w_fw;
    logic [RW:0]   w_fh;
    logic [15:0]   w_mh;

    assign w_cmd  = r_w0[31:24];
    assign w_adv2 = r_xaddr + AW'(2);
    assign w_advs = w_adv2 + AW'(r_xstride);
    assign w_rx   = {r_w1[15], r_w1[15:0]} + {{6{r_offx[10]}}, r_offx};
    assign w_ry   = {r_w1[31], r_w1[31:16]} + {{6{r_offy[10]}}, r_offy};
    assign w_mw   = ({1'b0, r_w2[15:0]} + 17'd1) & ~17'd1;
    assign w_mh   = r_w2[31:16];
    assign w_fw   = (w_mw == 17'd0) ? (CW+1)'(VRAM_COLS)
                  : {1'b0, CW'(w_mw - 17'd1)} + (CW+1)'(1);
    assign w_fh   = (w_mh == 16'd0) ? (RW+1)'(VRAM_ROWS)
                  : {1'b0, RW'(w_mh - 16'd1)} + (RW+1)'(1);

    always_comb begin
        unique case (w_cmd)
            CmdRectVar:                      w_need = NW'(3);
            CmdRect1, CmdRect8, CmdRect16:   w_need = NW'(2);
            CmdOffset:                       w_need = NW'(1);
            default: begin
                if ((w_cmd & gcfv_pkg::CmdClass) == gcfv_pkg::CmdUpload ||
                    (w_cmd & gcfv_pkg::CmdClass) == gcfv_pkg::CmdDownld) begin
                    w_need = NW'(3);
                end else begin
                    w_need = NW'(1);
                end
            end
        endcase
    end

    // advance of the transfer pointer, one word
    logic [AW-1:0] w_xa_n;
    logic [CW:0]   w_cols_n;
    logic [RW:0]   w_rows_n;
    logic [1:0]    w_xm_n;
    always_comb begin
        w_xm_n = r_xmode;
        w_rows_n = r_rows;
        if (r_cols <= (CW+1)'(2)) begin
            w_xa_n   = w_advs;
            w_cols_n = r_xwidth;
            if (r_rows != '0) begin
                w_rows_n = r_rows - (RW+1)'(1);
            end
            if (w_rows_n == '0) begin
                w_xm_n = gcfv_pkg::XF_NONE;
            end
        end else begin
            w_xa_n   = w_adv2;
            w_cols_n = r_cols - (CW+1)'(2);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_qcnt = r_qcnt; n_qhead = r_qhead;
        n_xmode = r_xmode; n_xaddr = r_xaddr; n_xwidth = r_xwidth;
        n_xstride = r_xstride; n_cols = r_cols; n_rows = r_rows;
        n_offx = r_offx; n_offy = r_offy; n_dma = r_dma;
        n_data = r_data; n_code = r_code; n_word = r_word;
        n_w0 = r_w0; n_w1 = r_w1; n_w2 = r_w2; n_rdsel = r_rdsel;
        n_fw = r_fw; n_fx = r_fx; n_fh = r_fh; n_fy = r_fy;
        n_pix = r_pix; n_rowa = r_rowa;
        w_qwe = 1'b0;
        w_qwa = q_idx({1'b0, r_qhead} + {1'b0, r_qcnt});
        w_qra = q_idx({1'b0, r_qhead});
        w_vwe = 1'b0; w_vwa = r_xaddr; w_vwd = r_word[15:0];
        w_vra = r_xaddr;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_state)
            gcfv_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_word = i_in.data_word;
                    n_data = '0;
                    n_code = gcfv_pkg::ST_OK;
                    n_state = gcfv_pkg::S_OUT;
                    unique case (gcfv_pkg::t_op'(i_in.opcode))
                        gcfv_pkg::OP_WR_GP0: begin
                            if (r_xmode == gcfv_pkg::XF_DOWNLOAD) begin
                                n_code = gcfv_pkg::ST_DROPPED;
                                n_xaddr = w_xa_n; n_cols = w_cols_n;
                                n_rows = w_rows_n; n_xmode = w_xm_n;
                            end else if (r_xmode == gcfv_pkg::XF_UPLOAD) begin
                                n_state = gcfv_pkg::S_UPL;
                            end else if (r_qcnt >= QFULL) begin
                                n_code = gcfv_pkg::ST_OVERFLOW;
                            end else begin
                                n_state = gcfv_pkg::S_RD0;
                                n_rdsel = 2'd0;
                            end
                        end
                        gcfv_pkg::OP_WR_GP1: begin
                            if (i_in.data_word[31:24] == gcfv_pkg::Gp1Reset) begin
                                n_qcnt = '0;
                            end else if (i_in.data_word[31:24] == gcfv_pkg::Gp1Dma) begin
                                n_dma = i_in.data_word[1:0];
                            end
                        end
                        gcfv_pkg::OP_RD_GP0: begin
                            if (r_xmode == gcfv_pkg::XF_DOWNLOAD) begin
                                n_state = gcfv_pkg::S_RD1;
                            end else begin
                                n_data = gcfv_pkg::AllOnes;
                                n_code = gcfv_pkg::ST_BAD_READ;
                            end
                        end
                        gcfv_pkg::OP_RD_GP1: begin
                            n_data = {1'b0, r_dma, 4'hF, 25'd0};
                        end
                        default: ;
                    endcase
                end
            end
            gcfv_pkg::S_UPL: begin
                // two pixels, low half this cycle, high half in S_RD2 path
                w_vwe = 1'b1; w_vwa = r_xaddr; w_vwd = r_word[15:0];
                n_xaddr = r_xaddr + AW'(1);
                n_state = gcfv_pkg::S_RD2;
                n_rdsel = 2'd3;
            end
            gcfv_pkg::S_RD1: begin
                // download: low pixel read issued
                w_vra = r_xaddr;
                n_xaddr = r_xaddr + AW'(1);
                n_rdsel = 2'd1;
                n_state = gcfv_pkg::S_RD2;
            end
            gcfv_pkg::S_RD2: begin
                if (r_rdsel == 2'd3) begin
                    w_vwe = 1'b1; w_vwa = r_xaddr; w_vwd = r_word[31:16];
                    n_xaddr = r_xaddr - AW'(1);
                    n_state = gcfv_pkg::S_DROP;
                    n_rdsel = 2'd0;
                end else if (r_rdsel == 2'd1) begin
                    w_vra = r_xaddr;
                    n_data[15:0] = r_vrd;
                    n_xaddr = r_xaddr - AW'(1);
                    n_rdsel = 2'd2;
                end else begin
                    n_data[31:16] = r_vrd;
                    n_state = gcfv_pkg::S_DROP;
                    n_rdsel = 2'd0;
                end
            end
            gcfv_pkg::S_RD0: begin
                // push word, then fetch three head words
                if (r_rdsel == 2'd0) begin
                    w_qwe = 1'b1;
                    n_qcnt = r_qcnt + NW'(1);
                    w_qra = q_idx({1'b0, r_qhead});
                    n_rdsel = 2'd1;
                end else if (r_rdsel == 2'd1) begin
                    // a word pushed into an empty queue is the head itself
                    n_w0 = (r_qcnt == NW'(1)) ? r_word : r_qrd;
                    w_qra = q_idx({1'b0, r_qhead} + (NW+1)'(1));
                    n_rdsel = 2'd2;
                end else if (r_rdsel == 2'd2) begin
                    n_w1 = r_qrd;
                    w_qra = q_idx({1'b0, r_qhead} + (NW+1)'(2));
                    n_rdsel = 2'd3;
                end else begin
                    n_w2 = r_qrd;
                    n_state = gcfv_pkg::S_DECODE;
                end
            end
            gcfv_pkg::S_DECODE: begin
                n_state = gcfv_pkg::S_OUT;
                if (r_qcnt >= w_need) begin
                    n_qhead = r_qhead + w_need;
                    n_qcnt  = r_qcnt - w_need;
                    if (QUEUE_DEPTH != (1 << QW)) begin
                        if (r_qhead + w_need >= QFULL) begin
                            n_qhead = r_qhead + w_need - QFULL;
                        end
                    end
                    if (w_cmd == CmdRectVar || w_cmd == CmdRect1 ||
                        w_cmd == CmdRect8 || w_cmd == CmdRect16) begin
                        n_pix = {1'b0, r_w0[23:19], r_w0[15:11], r_w0[7:3]};
                        n_fx = '0; n_fy = '0;
                        unique case (w_cmd)
                            CmdRect1:  begin n_fw = 11'd1;  n_fh = 10'd1;  end
                            CmdRect8:  begin n_fw = 11'd8;  n_fh = 10'd8;  end
                            CmdRect16: begin n_fw = 11'd16; n_fh = 10'd16; end
                            default: begin
                                n_fw = {1'b0, r_w2[9:0]}; n_fh = {1'b0, r_w2[24:16]};
                            end
                        endcase
                        if (!w_rx[16] && w_rx < 17'(VRAM_COLS) &&
                            !w_ry[16] && w_ry < 17'(VRAM_ROWS) &&
                            n_fw != '0 && n_fh != '0) begin
                            n_rowa = {RW'(w_ry), CW'(w_rx)};
                            n_state = gcfv_pkg::S_FILL;
                        end
                    end else if (w_cmd == CmdOffset) begin
                        n_offx = r_w0[10:0];
                        n_offy = r_w0[21:11];
                    end else if (w_need == NW'(3)) begin
                        n_state = gcfv_pkg::S_XFER_SETUP;
                    end
                end
            end
            gcfv_pkg::S_XFER_SETUP: begin
                n_xmode = ((w_cmd & gcfv_pkg::CmdClass) == gcfv_pkg::CmdUpload)
                        ? gcfv_pkg::XF_UPLOAD : gcfv_pkg::XF_DOWNLOAD;
                n_xaddr = {RW'(r_w1[31:16]), CW'(r_w1[15:0]) & ~CW'(1)};
                n_xwidth = w_fw;
                n_xstride = (CW+1)'(VRAM_COLS) - w_fw;
                n_cols = w_fw;
                n_rows = w_fh;
                n_state = gcfv_pkg::S_OUT;
            end
            gcfv_pkg::S_FILL: begin
                // one pixel per cycle, address wraps modulo vram size
                w_vwe = 1'b1;
                w_vwa = r_rowa + AW'(r_fx);
                w_vwd = r_pix;
                if (r_fx + 11'd1 >= r_fw) begin
                    n_fx = '0;
                    n_rowa = r_rowa + AW'(VRAM_COLS);
                    if (r_fy + 10'd1 >= r_fh) begin
                        n_state = gcfv_pkg::S_OUT;
                    end
                    n_fy = r_fy + 10'd1;
                end else begin
                    n_fx = r_fx + 11'd1;
                end
            end
            gcfv_pkg::S_DROP: begin
                // step transfer pointer after a word moved
                n_xaddr = w_xa_n; n_cols = w_cols_n;
                n_rows = w_rows_n; n_xmode = w_xm_n;
                n_state = gcfv_pkg::S_OUT;
            end
            gcfv_pkg::S_OUT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_state = gcfv_pkg::S_IDLE;
                end
            end
            default: n_state = gcfv_pkg::S_IDLE;
        endcase
    end

    assign o_out.read_data   = r_data;
    assign o_out.status_code = r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcfv_pkg::S_IDLE;
            r_qcnt <= '0; r_qhead <= '0;
            r_xmode <= gcfv_pkg::XF_NONE;
            r_xaddr <= '0; r_xwidth <= '0; r_xstride <= '0;
            r_cols <= '0; r_rows <= '0;
            r_offx <= '0; r_offy <= '0; r_dma <= '0;
        end else begin
            r_state <= n_state;
            r_qcnt <= n_qcnt; r_qhead <= n_qhead;
            r_xmode <= n_xmode;
            r_xaddr <= n_xaddr; r_xwidth <= n_xwidth; r_xstride <= n_xstride;
            r_cols <= n_cols; r_rows <= n_rows;
            r_offx <= n_offx; r_offy <= n_offy; r_dma <= n_dma;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data; r_code <= n_code; r_word <= n_word;
        r_w0 <= n_w0; r_w1 <= n_w1; r_w2 <= n_w2; r_rdsel <= n_rdsel;
        r_fw <= n_fw; r_fx <= n_fx; r_fh <= n_fh; r_fy <= n_fy;
        r_pix <= n_pix; r_rowa <= n_rowa;
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= QFULL) else $error("queue count over depth");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != gcfv_pkg::S_IDLE |-> !i_in.ready) else $error("ready while busy");
    a_xm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xmode != 2'd3) else $error("bad transfer mode");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gcfv_pkg::S_FILL |-> r_fx < r_fw) else $error("fill column overrun");
`endif
endmodule
`default_nettype wire
